/* rtl/rdbm_pkg.sv */
// Shared types and constants of the region decoded byte memory.
package rdbm_pkg;

  localparam int IN_TDATA_W  = 72;
  localparam int OUT_TDATA_W = 40;
  localparam int CFG_IDX_W   = 2;
  localparam int NUM_REGIONS = 3;
  localparam int NUM_BANKS   = 4;

  localparam logic OP_LOAD  = 1'b0;
  localparam logic OP_STORE = 1'b1;

  localparam logic [1:0] SZ_BYTE = 2'd0;
  localparam logic [1:0] SZ_HALF = 2'd1;
  localparam logic [1:0] SZ_WORD = 2'd2;
  localparam logic [1:0] SZ_BAD  = 2'd3;

  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_UNMAPPED = 2'd1;
  localparam logic [1:0] ST_BAD_SIZE = 2'd2;
  localparam logic [1:0] ST_CROSSES  = 2'd3;

  localparam logic [CFG_IDX_W-1:0] CFG_FLASH_BASE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_RAM_BASE   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_HEAP_BASE  = 2'd2;

  localparam logic [31:0] FLASH_BASE_RST = 32'h0000_0000;
  localparam logic [31:0] RAM_BASE_RST   = 32'h2000_0000;
  localparam logic [31:0] HEAP_BASE_RST  = 32'h4000_0000;

  typedef struct packed {
    logic clr;
    logic cap;
    logic dec;
    logic acc;
    logic ld_out;
  } cmd_t;

  typedef struct packed {
    logic clr_done;
  } sts_t;

endpackage

/* rtl/rdbm_bank.sv */
// One byte-wide single-port memory bank with registered read data.
module rdbm_bank #(
  parameter int ROWS = 4096,
  parameter int AW   = 12
) (
  input  logic          clk,
  input  logic          we,
  input  logic          re,
  input  logic [AW-1:0] addr,
  input  logic [7:0]    wdata,
  output logic [7:0]    rdata
);

  logic [7:0] mem [ROWS];
  logic [7:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[addr];
    end
  end

  assign rdata = rdata_r;

endmodule

/* rtl/rdbm_datapath.sv */
// Datapath: base registers, region decode, byte banks and result assembly.
module rdbm_datapath #(
  parameter int FLASH_DEPTH = 16384,
  parameter int RAM_DEPTH   = 16384,
  parameter int HEAP_DEPTH  = 16384
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_we,
  input  logic [rdbm_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [31:0]                    cfg_wdata,
  input  logic                           opcode,
  input  logic [31:0]                    byte_address,
  input  logic [1:0]                     access_size,
  input  logic [31:0]                    store_data,
  input  rdbm_pkg::cmd_t                 cmd,
  output rdbm_pkg::sts_t                 sts,
  output logic [31:0]                    load_data,
  output logic [1:0]                     status
);

  localparam int MAX_DEPTH = (FLASH_DEPTH > RAM_DEPTH) ?
                             ((FLASH_DEPTH > HEAP_DEPTH) ? FLASH_DEPTH : HEAP_DEPTH) :
                             ((RAM_DEPTH > HEAP_DEPTH) ? RAM_DEPTH : HEAP_DEPTH);
  localparam int MAX_ROWS  = (MAX_DEPTH + 3) / 4;
  localparam int CAW       = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
  localparam int OFS_W     = $clog2(MAX_DEPTH + 3);
  localparam int RW        = OFS_W - 2;

  logic [31:0]      base_r [rdbm_pkg::NUM_REGIONS];
  logic [CAW-1:0]   clr_row_r;
  logic             op_r;
  logic [1:0]       size_r;
  logic [31:0]      data_r;
  logic [32:0]      diff_r [rdbm_pkg::NUM_REGIONS];
  logic [2:0]       sel_r, sel_nxt;
  logic [OFS_W-1:0] ofs_r, ofs_nxt;
  logic [1:0]       st_r, st_nxt;
  logic [31:0]      load_data_r, res;
  logic [1:0]       status_r;
  logic [1:0]       last;
  logic [2:0]       hit, over_end;
  logic [1:0]       lane  [rdbm_pkg::NUM_BANKS];
  logic [OFS_W-1:0] rsum  [rdbm_pkg::NUM_BANKS];
  logic [RW-1:0]    row   [rdbm_pkg::NUM_BANKS];
  logic             wen   [rdbm_pkg::NUM_BANKS];
  logic [7:0]       wbyte [rdbm_pkg::NUM_BANKS];
  logic [7:0]       rbyte [rdbm_pkg::NUM_BANKS];
  logic [1:0]       idx   [rdbm_pkg::NUM_BANKS];
  logic [7:0]       rd_data [rdbm_pkg::NUM_REGIONS][rdbm_pkg::NUM_BANKS];
  logic [2:0][3:0]  bank_we;

  assign last = (size_r == rdbm_pkg::SZ_WORD) ? 2'd3 : size_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      base_r[0] <= rdbm_pkg::FLASH_BASE_RST;
      base_r[1] <= rdbm_pkg::RAM_BASE_RST;
      base_r[2] <= rdbm_pkg::HEAP_BASE_RST;
      clr_row_r <= '0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          rdbm_pkg::CFG_FLASH_BASE: base_r[0] <= cfg_wdata;
          rdbm_pkg::CFG_RAM_BASE:   base_r[1] <= cfg_wdata;
          rdbm_pkg::CFG_HEAP_BASE:  base_r[2] <= cfg_wdata;
          default: ;
        endcase
      end
      if (cmd.clr) begin
        clr_row_r <= clr_row_r + CAW'(1);
      end
    end
  end

  assign sts.clr_done = (clr_row_r == CAW'(MAX_ROWS - 1));

  always_ff @(posedge clk) begin
    if (cmd.cap) begin
      op_r   <= opcode;
      size_r <= access_size;
      data_r <= store_data;
      for (int k = 0; k < rdbm_pkg::NUM_REGIONS; k++) begin
        diff_r[k] <= {1'b0, byte_address} - {1'b0, base_r[k]};
      end
    end
    if (cmd.dec) begin
      sel_r <= sel_nxt;
      ofs_r <= ofs_nxt;
      st_r  <= st_nxt;
    end
    if (cmd.ld_out) begin
      load_data_r <= res;
      status_r    <= st_r;
    end
  end

  always_comb begin
    sel_nxt = 3'b000;
    if (hit[0]) begin
      sel_nxt = 3'b001;
    end else if (hit[1]) begin
      sel_nxt = 3'b010;
    end else if (hit[2]) begin
      sel_nxt = 3'b100;
    end
    if (sel_nxt[0]) begin
      ofs_nxt = diff_r[0][OFS_W-1:0];
    end else if (sel_nxt[1]) begin
      ofs_nxt = diff_r[1][OFS_W-1:0];
    end else begin
      ofs_nxt = diff_r[2][OFS_W-1:0];
    end
    if (size_r == rdbm_pkg::SZ_BAD) begin
      st_nxt = rdbm_pkg::ST_BAD_SIZE;
    end else if (sel_nxt == 3'b000) begin
      st_nxt = rdbm_pkg::ST_UNMAPPED;
    end else if (|(sel_nxt & over_end)) begin
      st_nxt = rdbm_pkg::ST_CROSSES;
    end else begin
      st_nxt = rdbm_pkg::ST_OK;
    end
  end

  always_comb begin
    for (int b = 0; b < rdbm_pkg::NUM_BANKS; b++) begin
      lane[b]  = 2'(b) - ofs_r[1:0];
      rsum[b]  = ofs_r + OFS_W'(lane[b]);
      row[b]   = rsum[b][OFS_W-1:2];
      wen[b]   = (op_r == rdbm_pkg::OP_STORE) && (st_r == rdbm_pkg::ST_OK) &&
                 (lane[b] <= last);
      wbyte[b] = data_r[8*lane[b] +: 8];
      rbyte[b] = (rd_data[0][b] & {8{sel_r[0]}}) | (rd_data[1][b] & {8{sel_r[1]}}) |
                 (rd_data[2][b] & {8{sel_r[2]}});
    end
  end

  always_comb begin
    res = '0;
    for (int i = 0; i < rdbm_pkg::NUM_BANKS; i++) begin
      idx[i] = ofs_r[1:0] + 2'(i);
      res[8*i +: 8] = (2'(i) <= last) ? rbyte[idx[i]] : 8'h00;
    end
    if ((op_r == rdbm_pkg::OP_STORE) || (st_r != rdbm_pkg::ST_OK)) begin
      res = '0;
    end
  end

  for (genvar k = 0; k < rdbm_pkg::NUM_REGIONS; k++) begin : g_region
    localparam int DEP  = (k == 0) ? FLASH_DEPTH : ((k == 1) ? RAM_DEPTH : HEAP_DEPTH);
    localparam int ROWS = (DEP + 3) / 4;
    localparam int AW   = (ROWS > 1) ? $clog2(ROWS) : 1;

    logic clr_ok;

    assign hit[k]      = !diff_r[k][32] && (diff_r[k][31:0] < 32'(DEP));
    assign over_end[k] = (diff_r[k][OFS_W-1:0] + OFS_W'(last)) >= OFS_W'(DEP);
    assign clr_ok      = cmd.clr && (32'(clr_row_r) < 32'(ROWS));

    for (genvar b = 0; b < rdbm_pkg::NUM_BANKS; b++) begin : g_bank
      logic          we;
      logic [AW-1:0] addr;
      logic [7:0]    wd;

      assign we   = clr_ok || (cmd.acc && sel_r[k] && wen[b]);
      assign addr = cmd.clr ? clr_row_r[AW-1:0] : row[b][AW-1:0];
      assign wd   = cmd.clr ? 8'h00 : wbyte[b];
      assign bank_we[k][b] = we && !cmd.clr;

      rdbm_bank #(
        .ROWS (ROWS),
        .AW   (AW)
      ) u_bank (
        .clk   (clk),
        .we    (we),
        .re    (cmd.acc),
        .addr  (addr),
        .wdata (wd),
        .rdata (rd_data[k][b])
      );
    end
  end

  assign load_data = load_data_r;
  assign status    = status_r;

  a_write_only_ok_store: assert property (@(posedge clk) disable iff (!rst_n)
    (|bank_we) |-> (op_r == rdbm_pkg::OP_STORE) && (st_r == rdbm_pkg::ST_OK))
    else $error("Bank written by a load or an errored store.");

  a_error_zero_data: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.ld_out && (st_r != rdbm_pkg::ST_OK)) |=> (load_data_r == 32'h0))
    else $error("Errored item returned nonzero data.");

endmodule

/* rtl/rdbm_ctrl.sv */
// Controller: clearing pass, item sequencing and output handshake.
module rdbm_ctrl (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_tvalid,
  output logic           in_tready,
  output logic           out_tvalid,
  input  logic           out_tready,
  input  rdbm_pkg::sts_t sts,
  output rdbm_pkg::cmd_t cmd
);

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_DEC,
    S_ACC,
    S_RESP
  } state_t;

  state_t state_r;
  logic   in_tready_r;
  logic   out_tvalid_r;

  always_comb begin
    cmd.clr    = (state_r == S_CLEAR);
    cmd.cap    = in_tvalid && in_tready_r;
    cmd.dec    = (state_r == S_DEC);
    cmd.acc    = (state_r == S_ACC);
    cmd.ld_out = (state_r == S_RESP) && (!out_tvalid_r || out_tready);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_CLEAR;
      in_tready_r  <= 1'b0;
      out_tvalid_r <= 1'b0;
    end else begin
      if (cmd.ld_out) begin
        out_tvalid_r <= 1'b1;
      end else if (out_tready) begin
        out_tvalid_r <= 1'b0;
      end
      unique case (state_r)
        S_CLEAR: begin
          if (sts.clr_done) begin
            state_r     <= S_IDLE;
            in_tready_r <= 1'b1;
          end
        end
        S_IDLE: begin
          if (in_tvalid) begin
            state_r     <= S_DEC;
            in_tready_r <= 1'b0;
          end
        end
        S_DEC: begin
          state_r <= S_ACC;
        end
        S_ACC: begin
          state_r <= S_RESP;
        end
        S_RESP: begin
          if (cmd.ld_out) begin
            state_r     <= S_IDLE;
            in_tready_r <= 1'b1;
          end
        end
        default: begin
          state_r <= S_CLEAR;
        end
      endcase
    end
  end

  assign in_tready  = in_tready_r;
  assign out_tvalid = out_tvalid_r;

  a_accept_then_decode: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready_r) |=> (cmd.dec && !in_tready_r))
    else $error("Accepted item was not decoded next.");

  a_decode_then_access: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.dec |=> cmd.acc)
    else $error("Decode was not followed by bank access.");

  a_result_from_resp: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_tvalid_r) |-> $past(state_r == S_RESP))
    else $error("Result appeared outside the response step.");

endmodule

/* rtl/region_decoded_byte_memory.sv */
// Top level of the region decoded byte memory.
// Three byte-addressed regions (flash, RAM, heap), each built from four byte-wide banks so
// that any aligned or unaligned access of one, two or four bytes is served in one bank
// access. After reset the block runs a clearing pass with in_tready low. Each item then passes
// in order through acceptance with the base subtraction, window decode, bank access and result
// assembly into the output register. The next item is accepted while the previous result
// still waits in the output register.
module region_decoded_byte_memory #(
  parameter int FLASH_DEPTH = 16384,
  parameter int RAM_DEPTH   = 16384,
  parameter int HEAP_DEPTH  = 16384
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             cfg_we,
  input  logic [rdbm_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [31:0]                      cfg_wdata,
  input  logic                             in_tvalid,
  output logic                             in_tready,
  // opcode, byte_address, access_size, store_data, zero pad
  input  logic [rdbm_pkg::IN_TDATA_W-1:0]  in_tdata,
  output logic                             out_tvalid,
  input  logic                             out_tready,
  // load_data, status, zero pad
  output logic [rdbm_pkg::OUT_TDATA_W-1:0] out_tdata
);

  rdbm_pkg::cmd_t cmd;
  rdbm_pkg::sts_t sts;
  logic [31:0]    load_data;
  logic [1:0]     status;

  rdbm_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .sts        (sts),
    .cmd        (cmd)
  );

  rdbm_datapath #(
    .FLASH_DEPTH (FLASH_DEPTH),
    .RAM_DEPTH   (RAM_DEPTH),
    .HEAP_DEPTH  (HEAP_DEPTH)
  ) u_datapath (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_wdata    (cfg_wdata),
    .opcode       (in_tdata[0]),
    .byte_address (in_tdata[32:1]),
    .access_size  (in_tdata[34:33]),
    .store_data   (in_tdata[66:35]),
    .cmd          (cmd),
    .sts          (sts),
    .load_data    (load_data),
    .status       (status)
  );

  assign out_tdata = {6'b000000, status, load_data};

endmodule
